@@ rtl/wns_pkg.sv @@
`timescale 1ns / 1ps
// Shared definitions for the wavetable note sequencer: table sizes, field widths,
// command codes, register indexes, inter-module structs and fixed-point helpers.
// No dependencies.
package wns_pkg;

  // Table sizes and sample resolution.
  localparam int WAVE_DEPTH  = 64;
  localparam int SONG_DEPTH  = 256;
  localparam int SAMPLE_BITS = 12;

  localparam int WAVE_W   = $clog2(WAVE_DEPTH);
  localparam int NOTE_W   = $clog2(SONG_DEPTH);
  localparam int PERIOD_W = 16;
  localparam int DUR_W    = 26;
  localparam int SONG_W   = PERIOD_W + DUR_W;
  localparam int AMP_W    = 9;
  localparam int LEN_W    = 9;

  // Full amplitude and the 95/100 decay step as one reciprocal multiply.
  localparam logic [AMP_W-1:0] FULL_AMP = 9'd400;
  localparam int DECAY_M     = 62260;
  localparam int DECAY_SHIFT = 16;
  localparam int DECAY_W     = AMP_W + DECAY_SHIFT;

  // Division by 400: a shift by 4, then a reciprocal multiply for the factor 25.
  localparam int PROD_W = SAMPLE_BITS + AMP_W;
  localparam int DIV_K  = SAMPLE_BITS + 10;
  localparam int DIV_M  = (2**DIV_K + 24) / 25;
  localparam int DIV_W  = 2 * SAMPLE_BITS + 11;

  typedef logic [WAVE_W-1:0]      wave_addr_t;
  typedef logic [NOTE_W-1:0]      note_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [PERIOD_W-1:0]    period_t;
  typedef logic [DUR_W-1:0]       dur_t;
  typedef logic [AMP_W-1:0]       amp_t;
  typedef logic [LEN_W-1:0]       len_t;
  typedef logic [PROD_W-1:0]      prod_t;
  typedef logic [DIV_W-1:0]       div_prod_t;
  typedef logic [DECAY_W-1:0]     decay_prod_t;

  // Command codes carried in the input tuser.
  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_SONG    = 3'd1,
    CMD_WAVE    = 3'd2,
    CMD_PLAY    = 3'd3,
    CMD_STOP    = 3'd4,
    CMD_RESTART = 3'd5
  } cmd_t;

  // Register select, taken from the word address bit of paddr.
  localparam logic REG_SONG_LENGTH = 1'b0;
  localparam logic REG_ENV_PERIOD  = 1'b1;

  // Write into the waveform table.
  typedef struct packed {
    logic       en;
    wave_addr_t addr;
    sample_t    data;
  } wave_wr_t;

  // One sample to be looked up and scaled.
  typedef struct packed {
    logic       valid;
    wave_addr_t addr;
    amp_t       amp;
    note_t      note;
  } sample_req_t;

  // A counter reload of zero counts as one.
  function automatic period_t nonzero16(input period_t v);
    return (v == '0) ? period_t'(1) : v;
  endfunction

  function automatic period_t period_reload(input period_t p);
    return nonzero16(p >> 1);
  endfunction

  function automatic dur_t dur_reload(input dur_t d);
    return (d == '0) ? dur_t'(1) : d;
  endfunction

  // amplitude * 95 / 100, exact for every 9-bit amplitude.
  function automatic amp_t amp_decay(input amp_t a);
    decay_prod_t t;
    t = decay_prod_t'(a) * decay_prod_t'(DECAY_M);
    return amp_t'(t >> DECAY_SHIFT);
  endfunction

  // Product / 400, exact over the whole product range.
  function automatic sample_t div_full_amp(input prod_t p);
    logic [PROD_W-5:0] x;
    div_prod_t t;
    x = p[PROD_W-1:4];
    t = div_prod_t'(x) * div_prod_t'(DIV_M);
    return sample_t'(t >> DIV_K);
  endfunction

endpackage

@@ rtl/wns_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// Read-first on a same-address collision. No dependencies.
module wns_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 12,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/wns_sequencer.sv @@
`timescale 1ns / 1ps
// Command decoder, song table and the sample, envelope and note counters.
// Depends on wns_pkg and wns_ram.
module wns_sequencer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  wns_pkg::cmd_t        cmd,
  input  logic [7:0]           slot,
  input  wns_pkg::period_t     tone_period,
  input  wns_pkg::dur_t        hold_ticks,
  input  logic [11:0]          wave_sample,
  input  wns_pkg::len_t        song_length,
  input  wns_pkg::period_t     envelope_period,
  output wns_pkg::wave_wr_t    wave_wr,
  output wns_pkg::sample_req_t req
);

  // Sequencer state.
  logic                 running;
  logic                 resting;
  logic                 pending;
  wns_pkg::wave_addr_t  wave_pos;
  wns_pkg::note_t       note_pos;
  wns_pkg::amp_t        amplitude;
  wns_pkg::period_t     sample_count;
  wns_pkg::period_t     envelope_count;
  wns_pkg::dur_t        note_count;
  wns_pkg::period_t     cur_period;
  wns_pkg::dur_t        cur_dur;

  logic                 running_next;
  logic                 resting_next;
  logic                 pending_next;
  wns_pkg::wave_addr_t  wave_pos_next;
  wns_pkg::note_t       note_pos_next;
  wns_pkg::amp_t        amplitude_next;
  wns_pkg::period_t     sample_count_next;
  wns_pkg::period_t     envelope_count_next;
  wns_pkg::dur_t        note_count_next;
  wns_pkg::period_t     cur_period_next;
  wns_pkg::dur_t        cur_dur_next;

  // Values in effect this cycle, with a pending note load folded in.
  wns_pkg::period_t     rd_period;
  wns_pkg::dur_t        rd_dur;
  wns_pkg::period_t     src_period;
  wns_pkg::dur_t        src_dur;
  logic                 resting_e;
  wns_pkg::dur_t        note_e;
  wns_pkg::period_t     sample_e;
  wns_pkg::period_t     sample_rl;
  wns_pkg::dur_t        note_rl;
  wns_pkg::period_t     env_rl;

  logic                 tick;
  logic                 sounding;
  logic                 s_exp;
  logic                 e_exp;
  logic                 n_exp;
  logic                 song_ok;
  logic                 wave_ok;
  wns_pkg::wave_addr_t  wave_inc;
  logic [wns_pkg::NOTE_W:0] note_inc;
  wns_pkg::note_t       note_wrap;
  wns_pkg::note_t       song_raddr;
  logic [wns_pkg::SONG_W-1:0] song_rdata;

  // Song table: period in the low bits, duration above. The read port always
  // follows the note index the state will hold after this edge.
  wns_ram #(
    .DEPTH (wns_pkg::SONG_DEPTH),
    .WIDTH (wns_pkg::SONG_W)
  ) u_song_ram (
    .clk   (clk),
    .we    (accept && song_ok),
    .waddr (wns_pkg::note_t'(slot)),
    .wdata ({hold_ticks, tone_period}),
    .re    (1'b1),
    .raddr (song_raddr),
    .rdata (song_rdata)
  );

  assign rd_period  = song_rdata[wns_pkg::PERIOD_W-1:0];
  assign rd_dur     = song_rdata[wns_pkg::SONG_W-1:wns_pkg::PERIOD_W];
  assign song_raddr = accept ? note_pos_next : note_pos;

  // Effective note data. A note change only sets pending; the entry read for
  // the new note arrives from the registered song RAM read and is applied here.
  always_comb begin
    src_period = pending ? rd_period : cur_period;
    src_dur    = pending ? rd_dur : cur_dur;
    resting_e  = pending ? (rd_period == '0) : resting;
    note_e     = pending ? wns_pkg::dur_reload(rd_dur) : note_count;
    sample_e   = (pending && rd_period != '0) ? wns_pkg::period_reload(rd_period)
                                              : sample_count;
    sample_rl  = wns_pkg::period_reload(src_period);
    note_rl    = wns_pkg::dur_reload(src_dur);
    env_rl     = wns_pkg::nonzero16(envelope_period);
  end

  // Index steps with wrap.
  always_comb begin
    wave_inc = (wave_pos == wns_pkg::wave_addr_t'(wns_pkg::WAVE_DEPTH - 1))
             ? '0 : wave_pos + 1'b1;
    note_inc = {1'b0, note_pos} + 1'b1;
    if (32'(note_inc) >= 32'(song_length) || 32'(note_inc) >= wns_pkg::SONG_DEPTH) begin
      note_wrap = '0;
    end else begin
      note_wrap = wns_pkg::note_t'(note_inc);
    end
  end

  // Expiry conditions for a tick.
  assign tick     = (cmd == wns_pkg::CMD_TICK) && running;
  assign sounding = tick && !resting_e;
  assign s_exp    = sounding && (sample_e <= 16'd1);
  assign e_exp    = sounding && (envelope_count <= 16'd1);
  assign n_exp    = tick && (note_e <= 26'd1);

  // Next-state decode for one accepted command.
  always_comb begin
    running_next        = running;
    resting_next        = resting_e;
    pending_next        = 1'b0;
    wave_pos_next       = wave_pos;
    note_pos_next       = note_pos;
    amplitude_next      = amplitude;
    sample_count_next   = sample_e;
    envelope_count_next = envelope_count;
    note_count_next     = note_e;
    cur_period_next     = src_period;
    cur_dur_next        = src_dur;
    song_ok             = 1'b0;
    wave_ok             = 1'b0;
    unique case (cmd)
      wns_pkg::CMD_TICK: begin
        if (sounding) begin
          sample_count_next   = s_exp ? sample_rl : sample_e - 16'd1;
          envelope_count_next = e_exp ? env_rl : envelope_count - 16'd1;
          if (s_exp) begin
            wave_pos_next = wave_inc;
          end
          if (e_exp) begin
            amplitude_next = wns_pkg::amp_decay(amplitude);
          end
        end
        if (tick) begin
          note_count_next = n_exp ? note_rl : note_e - 26'd1;
          if (n_exp) begin
            amplitude_next = wns_pkg::FULL_AMP;
            note_pos_next  = note_wrap;
            pending_next   = 1'b1;
          end
        end
      end
      wns_pkg::CMD_SONG: begin
        song_ok = 32'(slot) < wns_pkg::SONG_DEPTH;
        // Keep the cached entry of the playing note in step with the table.
        if (song_ok && wns_pkg::note_t'(slot) == note_pos) begin
          cur_period_next = tone_period;
          cur_dur_next    = hold_ticks;
        end
      end
      wns_pkg::CMD_WAVE: begin
        wave_ok = 32'(slot) < wns_pkg::WAVE_DEPTH;
      end
      wns_pkg::CMD_PLAY: begin
        running_next = 1'b1;
      end
      wns_pkg::CMD_STOP: begin
        running_next = 1'b0;
      end
      wns_pkg::CMD_RESTART: begin
        wave_pos_next  = '0;
        note_pos_next  = '0;
        amplitude_next = wns_pkg::FULL_AMP;
        pending_next   = 1'b1;
        running_next   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Outputs to the scaler.
  always_comb begin
    wave_wr.en   = accept && wave_ok;
    wave_wr.addr = wns_pkg::wave_addr_t'(slot);
    wave_wr.data = wns_pkg::sample_t'(wave_sample);
    req.valid    = accept && s_exp;
    req.addr     = wave_inc;
    req.amp      = amplitude;
    req.note     = note_pos;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      running        <= 1'b0;
      resting        <= 1'b0;
      pending        <= 1'b0;
      wave_pos       <= '0;
      note_pos       <= '0;
      amplitude      <= wns_pkg::FULL_AMP;
      sample_count   <= '0;
      envelope_count <= '0;
      note_count     <= '0;
    end else if (accept) begin
      running        <= running_next;
      resting        <= resting_next;
      pending        <= pending_next;
      wave_pos       <= wave_pos_next;
      note_pos       <= note_pos_next;
      amplitude      <= amplitude_next;
      sample_count   <= sample_count_next;
      envelope_count <= envelope_count_next;
      note_count     <= note_count_next;
    end
  end

  // Cached song entry of the playing note.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_period <= cur_period_next;
      cur_dur    <= cur_dur_next;
    end
  end

`ifndef SYNTHESIS
  a_pending_running: assert property (@(posedge clk) disable iff (rst)
    pending |-> running)
    else $error("note load pending while stopped");
  a_note_change: assert property (@(posedge clk) disable iff (rst)
    (accept && n_exp) |=> (pending && amplitude == wns_pkg::FULL_AMP))
    else $error("note change did not queue a load at full amplitude");
  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == wns_pkg::CMD_TICK && !running) |=>
    ($stable(note_pos) && $stable(sample_count) && $stable(amplitude)))
    else $error("tick while stopped changed the sequencer state");
`endif

endmodule

@@ rtl/wns_scaler.sv @@
`timescale 1ns / 1ps
// Waveform table and the output pipeline: table read, amplitude multiply,
// division by full amplitude into the output register. Depends on wns_pkg, wns_ram.
module wns_scaler (
  input  logic                 clk,
  input  logic                 rst,
  input  wns_pkg::sample_req_t req,
  input  wns_pkg::wave_wr_t    wave_wr,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wns_pkg::sample_t     dac,
  output wns_pkg::note_t       note
);

  logic              s1_valid;
  wns_pkg::amp_t     s1_amp;
  wns_pkg::note_t    s1_note;
  wns_pkg::sample_t  wave_rdata;

  logic              s2_valid;
  wns_pkg::prod_t    s2_prod;
  wns_pkg::note_t    s2_note;

  logic              out_move;
  logic              s2_move;
  logic              s1_move;

  // Waveform table; a read is issued only when a sample enters the pipeline,
  // so the read data holds while that stage waits.
  wns_ram #(
    .DEPTH (wns_pkg::WAVE_DEPTH),
    .WIDTH (wns_pkg::SAMPLE_BITS)
  ) u_wave_ram (
    .clk   (clk),
    .we    (wave_wr.en),
    .waddr (wave_wr.addr),
    .wdata (wave_wr.data),
    .re    (req.valid),
    .raddr (req.addr),
    .rdata (wave_rdata)
  );

  // Each stage advances when the one after it is empty or moving.
  assign out_move = !out_valid || out_ready;
  assign s2_move  = !s2_valid || out_move;
  assign s1_move  = !s1_valid || s2_move;
  assign ready    = s1_move;

  // Stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_move) begin
        s1_valid <= req.valid;
      end
      if (s2_move) begin
        s2_valid <= s1_valid;
      end
      if (out_move) begin
        out_valid <= s2_valid;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (s1_move && req.valid) begin
      s1_amp  <= req.amp;
      s1_note <= req.note;
    end
    if (s2_move && s1_valid) begin
      s2_prod <= wns_pkg::prod_t'(wave_rdata) * wns_pkg::prod_t'(s1_amp);
      s2_note <= s1_note;
    end
    if (out_move && s2_valid) begin
      dac  <= wns_pkg::div_full_amp(s2_prod);
      note <= s2_note;
    end
  end

`ifndef SYNTHESIS
  a_req_has_room: assert property (@(posedge clk) disable iff (rst)
    req.valid |-> ready)
    else $error("sample request arrived with the first stage blocked");
`endif

endmodule

@@ rtl/wavetable_note_sequencer.sv @@
`timescale 1ns / 1ps
// Top level of the wavetable note sequencer: stream ports, APB registers and
// the sequencer and scaler instances. Depends on wns_pkg, wns_sequencer, wns_scaler.
//
// Usage:
//   The input stream carries one command per transfer: tuser holds the command
//   (tick, write song entry, write wave entry, play, stop, restart) and tdata the
//   entry fields. One tick per clock is sustained while s_tready is not held low
//   by a stalled output stream; the counters are registers and the song entry of
//   a new note is read from the registered song RAM in the cycle after the note change.
//   A tick whose sample counter expires yields one output transfer: the scaled
//   waveform code and the note index. The result passes through the wave RAM
//   read, the multiply and the divide into the output register. Ticks without
//   a result and other commands yield nothing.
//   When the receiver stalls, the result holds in the output register and the
//   two stages before it keep filling; s_tready drops only when all three hold
//   a sample.
//   The two registers, song_length and envelope_period, are written over APB;
//   the user must write them while the stream is idle, the block does not enforce
//   it. Reset clears the counters, indexes and flags and sets full amplitude;
//   the wave and song tables are not cleared and must be loaded before play.
module wavetable_note_sequencer (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata from bit 0: slot[7:0], tone_period[15:0], hold_ticks[25:0],
  // wave_sample[11:0], two zero pad bits.
  input  logic [63:0] s_tdata,
  // tuser: cmd[2:0].
  input  logic [2:0]  s_tuser,
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata from bit 0: dac_code[11:0], current_note[7:0], four zero pad bits.
  output logic [23:0] m_tdata,
  // tuser: in_rest.
  output logic        m_tuser,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  wns_pkg::len_t        song_length;
  wns_pkg::period_t     envelope_period;
  logic                 cfg_wr;
  logic                 accept;
  wns_pkg::wave_wr_t    wave_wr;
  wns_pkg::sample_req_t req;
  wns_pkg::sample_t     dac;
  wns_pkg::note_t       note;

  // Registers are word addressed; paddr[2] selects the register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      song_length     <= 9'd1;
      envelope_period <= 16'd1000;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        wns_pkg::REG_SONG_LENGTH: song_length     <= pwdata[8:0];
        wns_pkg::REG_ENV_PERIOD:  envelope_period <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (paddr[2])
      wns_pkg::REG_SONG_LENGTH: prdata = {23'd0, song_length};
      wns_pkg::REG_ENV_PERIOD:  prdata = {16'd0, envelope_period};
      default:                  prdata = '0;
    endcase
  end

  assign accept = s_tvalid && s_tready;

  wns_sequencer u_sequencer (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .cmd             (wns_pkg::cmd_t'(s_tuser)),
    .slot            (s_tdata[7:0]),
    .tone_period     (s_tdata[23:8]),
    .hold_ticks      (s_tdata[49:24]),
    .wave_sample     (s_tdata[61:50]),
    .song_length     (song_length),
    .envelope_period (envelope_period),
    .wave_wr         (wave_wr),
    .req             (req)
  );

  wns_scaler u_scaler (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .wave_wr   (wave_wr),
    .ready     (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .dac       (dac),
    .note      (note)
  );

  // Samples are only produced on sounding notes, so the rest flag is clear.
  assign m_tdata = {4'd0, 8'(note), 12'(dac)};
  assign m_tuser = 1'b0;

endmodule

@@ tb/wns_note_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the wavetable note sequencer: watches the input stream, the
// output stream and the APB writes, predicts every output transfer and compares it.
// Depends on wns_pkg.
module wns_note_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // tdata from bit 0: slot[7:0], tone_period[15:0], hold_ticks[25:0], wave_sample[11:0].
  input  logic [63:0] s_tdata,
  // tuser: cmd[2:0].
  input  logic [2:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // tdata from bit 0: dac_code[11:0], current_note[7:0].
  input  logic [23:0] m_tdata,
  // tuser: in_rest.
  input  logic        m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          outstanding,
  output int          checked
);

  localparam int DECAY_PCT = 95;
  localparam int PCT_SCALE = 100;

  typedef struct packed {
    wns_pkg::sample_t dac;
    wns_pkg::note_t   note;
    logic             rest;
  } tone_out_t;

  // Expected output transfers, oldest first.
  tone_out_t  pending_tones[$];
  tone_out_t  fresh;
  tone_out_t  head;

  // Shadow copy of the tables, counters and registers.
  wns_pkg::sample_t    wave_mem [wns_pkg::WAVE_DEPTH];
  wns_pkg::period_t    period_mem [wns_pkg::SONG_DEPTH];
  wns_pkg::dur_t       dur_mem [wns_pkg::SONG_DEPTH];
  wns_pkg::wave_addr_t wave_idx;
  wns_pkg::note_t      note_idx;
  int                  amp;
  wns_pkg::period_t    samp_left;
  wns_pkg::period_t    env_left;
  wns_pkg::dur_t       note_left;
  logic                resting;
  logic                running;
  wns_pkg::len_t       song_len;
  wns_pkg::period_t    env_period;
  int                  fail_count;
  int                  match_count;

  // Input fields of the current transfer.
  logic [7:0]       in_slot;
  wns_pkg::period_t in_per;
  wns_pkg::dur_t    in_hold;
  wns_pkg::sample_t in_wave;

  assign in_slot = s_tdata[7:0];
  assign in_per  = s_tdata[23:8];
  assign in_hold = s_tdata[49:24];
  assign in_wave = s_tdata[61:50];

  // A reload of zero is taken as one tick.
  function automatic wns_pkg::period_t half_period(input wns_pkg::period_t p);
    return ((p >> 1) == '0) ? wns_pkg::period_t'(1) : (p >> 1);
  endfunction

  function automatic wns_pkg::dur_t hold_len(input wns_pkg::dur_t d);
    return (d == '0) ? wns_pkg::dur_t'(1) : d;
  endfunction

  task automatic enter_note();
    resting = (period_mem[note_idx] == '0);
    note_left = hold_len(dur_mem[note_idx]);
    if (!resting) begin
      samp_left = half_period(period_mem[note_idx]);
    end
  endtask

  // One tick: sample counter, then envelope, then note.
  task automatic take_tick();
    int scaled;
    int next_note;
    if (!running) return;
    if (!resting) begin
      if (samp_left <= 1) begin
        samp_left = half_period(period_mem[note_idx]);
        wave_idx = wave_idx + 1'b1;
        scaled = (int'(wave_mem[wave_idx]) * amp) / int'(wns_pkg::FULL_AMP);
        fresh.dac = wns_pkg::sample_t'(scaled);
        fresh.note = note_idx;
        fresh.rest = 1'b0;
        pending_tones.push_back(fresh);
      end else begin
        samp_left = samp_left - 1'b1;
      end
      if (env_left <= 1) begin
        env_left = (env_period == '0) ? wns_pkg::period_t'(1) : env_period;
        amp = (amp * DECAY_PCT) / PCT_SCALE;
      end else begin
        env_left = env_left - 1'b1;
      end
    end
    if (note_left <= 1) begin
      amp = int'(wns_pkg::FULL_AMP);
      next_note = int'(note_idx) + 1;
      if (next_note >= int'(song_len) || next_note >= wns_pkg::SONG_DEPTH) next_note = 0;
      note_idx = wns_pkg::note_t'(next_note);
      enter_note();
    end else begin
      note_left = note_left - 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pending_tones.delete();
      wave_idx = '0;
      note_idx = '0;
      amp = int'(wns_pkg::FULL_AMP);
      samp_left = '0;
      env_left = '0;
      note_left = '0;
      resting = 1'b0;
      running = 1'b0;
      song_len = wns_pkg::len_t'(1);
      env_period = wns_pkg::period_t'(1000);
      fail_count = 0;
      match_count = 0;
    end else begin
      // Output transfers belong to earlier input, so compare before predicting.
      if (m_tvalid && m_tready) begin
        if (pending_tones.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual dac=%0d note=%0d rest=%0b",
                   $time, m_tdata[11:0], m_tdata[19:12], m_tuser);
        end else begin
          head = pending_tones.pop_front();
          match_count++;
          if (m_tdata[11:0] !== head.dac) begin
            fail_count++;
            $display("%0t: dac_code mismatch, expected %0d, actual %0d",
                     $time, head.dac, m_tdata[11:0]);
          end
          if (m_tdata[19:12] !== head.note) begin
            fail_count++;
            $display("%0t: current_note mismatch, expected %0d, actual %0d",
                     $time, head.note, m_tdata[19:12]);
          end
          if (m_tuser !== head.rest) begin
            fail_count++;
            $display("%0t: in_rest mismatch, expected %0b, actual %0b",
                     $time, head.rest, m_tuser);
          end
        end
      end

      // Register writes complete on the access cycle.
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == wns_pkg::REG_ENV_PERIOD) env_period = pwdata[15:0];
        else song_len = pwdata[8:0];
      end

      if (s_tvalid && s_tready) begin
        case (s_tuser)
          wns_pkg::CMD_TICK: take_tick();
          wns_pkg::CMD_SONG: begin
            period_mem[in_slot] = in_per;
            dur_mem[in_slot] = in_hold;
          end
          wns_pkg::CMD_WAVE: begin
            if (in_slot < wns_pkg::WAVE_DEPTH) begin
              wave_mem[in_slot[wns_pkg::WAVE_W-1:0]] = in_wave;
            end
          end
          wns_pkg::CMD_PLAY: running = 1'b1;
          wns_pkg::CMD_STOP: running = 1'b0;
          wns_pkg::CMD_RESTART: begin
            wave_idx = '0;
            note_idx = '0;
            amp = int'(wns_pkg::FULL_AMP);
            enter_note();
            running = 1'b1;
          end
          default: ;
        endcase
      end
    end
    errors <= fail_count;
    outstanding <= pending_tones.size();
    checked <= match_count;
  end

endmodule

@@ tb/tb_wavetable_note_sequencer.sv @@
`timescale 1ns / 1ps
// Top of the wavetable note sequencer testbench: clock, reset, stream and APB
// stimulus, and the verdict. Depends on wns_pkg, wavetable_note_sequencer, wns_note_checker.
module tb_wavetable_note_sequencer;

  // Command codes the block must ignore.
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  // Byte addresses of the two registers.
  localparam logic [2:0] ADDR_SONG_LENGTH = 3'd0;
  localparam logic [2:0] ADDR_ENV_PERIOD  = 3'd4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // tdata from bit 0: slot[7:0], tone_period[15:0], hold_ticks[25:0],
  // wave_sample[11:0], two zero pad bits.
  logic [63:0] s_tdata = '0;
  // tuser: cmd[2:0].
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // tdata from bit 0: dac_code[11:0], current_note[7:0], four zero pad bits.
  logic [23:0] m_tdata;
  // tuser: in_rest.
  logic        m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int outstanding;
  int checked;
  int items_sent = 0;
  int settings = 0;
  bit calm = 1'b0;
  bit playing = 1'b0;

  wavetable_note_sequencer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  wns_note_checker scoreboard (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .errors(errors), .outstanding(outstanding), .checked(checked)
  );

  always #5 clk = ~clk;

  // The receiver stalls now and then, except during a calm stretch.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= calm || ($urandom_range(99) >= 11);
  end

  // One input transfer, with random idle cycles ahead of it.
  task automatic push_item(input logic [2:0] code, input logic [7:0] slot,
                           input wns_pkg::period_t per, input wns_pkg::dur_t hold,
                           input wns_pkg::sample_t wv);
    while (!calm && $urandom_range(99) < 11) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tuser <= code;
    s_tdata <= {2'b00, wv, hold, per, slot};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Commands whose data fields the block ignores carry random data.
  task automatic push_cmd(input logic [2:0] code);
    push_item(code, 8'($urandom), wns_pkg::period_t'($urandom), wns_pkg::dur_t'($urandom),
              wns_pkg::sample_t'($urandom));
  endtask

  task automatic write_note(input logic [7:0] slot, input wns_pkg::period_t per,
                            input wns_pkg::dur_t hold);
    push_item(wns_pkg::CMD_SONG, slot, per, hold, wns_pkg::sample_t'($urandom));
  endtask

  task automatic write_wave(input logic [7:0] slot, input wns_pkg::sample_t wv);
    push_item(wns_pkg::CMD_WAVE, slot, wns_pkg::period_t'($urandom),
              wns_pkg::dur_t'($urandom), wv);
  endtask

  // Stop sending and wait until every predicted result has been taken.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_regs(input wns_pkg::len_t len, input wns_pkg::period_t env);
    apb_write(ADDR_SONG_LENGTH, 32'(len));
    apb_write(ADDR_ENV_PERIOD, 32'(env));
    settings++;
  endtask

  // Mostly short periods so that samples come often; some rests, some huge.
  function automatic wns_pkg::period_t pick_period();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 50) return wns_pkg::period_t'($urandom_range(1, 3));
    if (r < 95) return wns_pkg::period_t'($urandom_range(4, 40));
    return wns_pkg::period_t'($urandom);
  endfunction

  // A restart followed by a tick-heavy mix of every command. Long notes go only
  // to high slots, which later short songs never reach.
  task automatic run_phase(input wns_pkg::len_t len, input wns_pkg::period_t env,
                           input int wanted, input int dur_max, input bit long_ok);
    int made;
    int r;
    logic [7:0] s;
    drain();
    set_regs(len, env);
    push_cmd(wns_pkg::CMD_RESTART);
    playing = 1'b1;
    made = 0;
    while (made < wanted) begin
      r = $urandom_range(999);
      s = 8'($urandom);
      if (!playing && $urandom_range(3) == 0) begin
        push_cmd(wns_pkg::CMD_PLAY);
        playing = 1'b1;
        made++;
      end else if (r < 40) begin
        if (long_ok && s >= 8'd224) begin
          write_note(s, wns_pkg::period_t'($urandom), wns_pkg::dur_t'($urandom));
        end else begin
          write_note(s, pick_period(), wns_pkg::dur_t'($urandom_range(0, dur_max)));
        end
        made++;
      end else if (r < 70) begin
        write_wave(s, wns_pkg::sample_t'($urandom));
        made++;
      end else if (r < 85) begin
        push_cmd(wns_pkg::CMD_STOP);
        playing = 1'b0;
        made++;
      end else if (r < 100) begin
        push_cmd(wns_pkg::CMD_PLAY);
        playing = 1'b1;
        made++;
      end else if (r < 110) begin
        push_cmd(wns_pkg::CMD_RESTART);
        playing = 1'b1;
        made++;
      end else if (r < 120) begin
        push_cmd(r[0] ? CMD_SPARE_HI : CMD_SPARE_LO);
      end else begin
        push_cmd(wns_pkg::CMD_TICK);
        if (playing) made++;
      end
    end
  endtask

  // Run time limit, far above the slowest correct run.
  initial begin
    #2_000_000;
    $display("Run timed out with %0d results still expected.", outstanding);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int k;
    wns_pkg::period_t env;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    drain();
    set_regs(wns_pkg::len_t'(2), wns_pkg::period_t'(1));

    // Fill both tables so that no entry is ever read unwritten.
    for (k = 0; k < wns_pkg::WAVE_DEPTH; k++) begin
      if (k == 5) write_wave(8'(k), wns_pkg::sample_t'(4095));
      else if (k == 6) write_wave(8'(k), '0);
      else write_wave(8'(k), wns_pkg::sample_t'($urandom));
    end
    for (k = 0; k < wns_pkg::SONG_DEPTH; k++) begin
      write_note(8'(k), pick_period(), wns_pkg::dur_t'($urandom_range(0, 2)));
    end

    // Directed: play from reset, stop, a tick while stopped, unused codes,
    // out-of-range slots, field extremes, a rest and a fast decay.
    push_cmd(wns_pkg::CMD_PLAY);
    repeat (3) push_cmd(wns_pkg::CMD_TICK);
    push_cmd(wns_pkg::CMD_STOP);
    push_cmd(wns_pkg::CMD_TICK);
    push_cmd(wns_pkg::CMD_PLAY);
    push_cmd(CMD_SPARE_LO);
    push_cmd(CMD_SPARE_HI);
    write_wave(8'd255, wns_pkg::sample_t'(4095));
    write_wave(8'd63, wns_pkg::sample_t'(4095));
    write_wave(8'd0, '0);
    write_note(8'd255, wns_pkg::period_t'(16'hFFFF), wns_pkg::dur_t'(26'h3FFFFFF));
    write_note(8'd0, wns_pkg::period_t'(1), '0);
    write_note(8'd1, '0, wns_pkg::dur_t'(3));
    push_cmd(wns_pkg::CMD_RESTART);
    repeat (8) push_cmd(wns_pkg::CMD_TICK);
    // The last slot must be short again before the long songs run through it.
    write_note(8'd255, pick_period(), wns_pkg::dur_t'(1));

    // A song longer than the table, an empty song, a full-table song, then short random songs.
    run_phase(wns_pkg::len_t'(511), wns_pkg::period_t'(1), 230, 2, 1'b0);
    run_phase('0, '0, 60, 8, 1'b0);
    drain();
    calm <= 1'b1;
    run_phase(wns_pkg::len_t'(256), wns_pkg::period_t'(16'hFFFF), 180, 2, 1'b0);
    drain();
    calm <= 1'b0;
    for (k = 0; k < 6; k++) begin
      case ($urandom_range(3))
        0: env = wns_pkg::period_t'(1);
        1: env = wns_pkg::period_t'(2);
        2: env = wns_pkg::period_t'(16'hFFFF);
        default: env = wns_pkg::period_t'($urandom_range(3, 60));
      endcase
      run_phase((k == 0) ? wns_pkg::len_t'(1) : wns_pkg::len_t'($urandom_range(2, 32)),
                env, 20, 12, 1'b1);
    end

    drain();
    $display("Covered %0d input transfers under %0d register settings;", items_sent, settings);
    $display("%0d output transfers were compared against the prediction.", checked);
    if (errors == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
